// File: design/mx4_pkg.sv
// shared types and constants of the 4x4 fixed-point matrix multiplier
// used by mx4_cell, mx4_sat and matrix4_multiply; depends on nothing

package mx4_pkg;

    localparam int unsigned DIM            = 4;
    localparam int unsigned ROW_W          = 2;
    localparam int unsigned OUT_W          = 32;
    localparam int unsigned DEF_FRAC_BITS  = 16;
    localparam int unsigned DEF_ELEM_WIDTH = 32;

    localparam int unsigned FIELD_BITS = ROW_W + DIM * OUT_W;
    localparam int unsigned TDATA_W    = ((FIELD_BITS + 7) / 8) * 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MUL  = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [ROW_W-1:0] row;
    } t_ctl;

endpackage

// File: design/matrix4_multiply.sv
// top level of the 4x4 fixed-point matrix multiplier, C = A x B
// depends on mx4_pkg, mx4_cell and mx4_sat

// One beat is taken every cycle unless the result beat waits. A beat with
// tuser 0 stores its row into B; tuser 1 sends a row of A down a chain of
// four cells, each holding one row of B and adding its term of all four
// dot products, two register stages per cell, then a shift-and-clip
// stage. A multiply beat shows its product row after passing all of
// them; a load beat updates B in order with the rows in flight, so a
// load followed at once by a multiply is seen by that multiply. The whole
// chain halts while the output beat is held by m_axis_tready low.

module matrix4_multiply #(
    parameter int unsigned FRAC_BITS  = mx4_pkg::DEF_FRAC_BITS,
    parameter int unsigned ELEM_WIDTH = mx4_pkg::DEF_ELEM_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // row, elem0, elem1, elem2, elem3, zero pad
    input  logic [mx4_pkg::TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // row_out, prod0, prod1, prod2, prod3, zero pad
    output logic [mx4_pkg::TDATA_W-1:0]   m_axis_tdata,
    // saturated
    output logic                          m_axis_tuser
);

    localparam int unsigned ACC_W = 2 * ELEM_WIDTH + 2;
    localparam logic [mx4_pkg::OUT_W-1:0] SAT_HI =
        mx4_pkg::OUT_W'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
    localparam logic [mx4_pkg::OUT_W-1:0] SAT_LO = ~SAT_HI;

    mx4_pkg::t_ctl                            w_ctl  [mx4_pkg::DIM+1];
    logic [mx4_pkg::DIM-1:0][ELEM_WIDTH-1:0]  w_elem [mx4_pkg::DIM+1];
    logic [mx4_pkg::DIM-1:0][ACC_W-1:0]       w_acc  [mx4_pkg::DIM+1];

    logic                                         w_en;
    logic                                         w_valid;
    logic [mx4_pkg::ROW_W-1:0]                    w_row;
    logic [mx4_pkg::DIM-1:0][mx4_pkg::OUT_W-1:0]  w_prod;
    logic                                         w_sat;

    assign w_en          = !w_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        w_ctl[0].valid = s_axis_tvalid;
        w_ctl[0].kind  = s_axis_tuser;
        w_ctl[0].row   = s_axis_tdata[mx4_pkg::ROW_W-1:0];
        for (int j = 0; j < mx4_pkg::DIM; j++) begin
            w_elem[0][j] = s_axis_tdata[mx4_pkg::ROW_W + j*mx4_pkg::OUT_W +: ELEM_WIDTH];
        end
        w_acc[0] = '0;
    end

    for (genvar k = 0; k < mx4_pkg::DIM; k++) begin : g_cell
        mx4_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX        (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_elem  (w_elem[k]),
            .i_acc   (w_acc[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_elem  (w_elem[k+1]),
            .o_acc   (w_acc[k+1])
        );
    end

    mx4_sat #(
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[mx4_pkg::DIM]),
        .i_acc   (w_acc[mx4_pkg::DIM]),
        .o_valid (w_valid),
        .o_row   (w_row),
        .o_prod  (w_prod),
        .o_sat   (w_sat)
    );

    assign m_axis_tvalid = w_valid;
    assign m_axis_tdata  = mx4_pkg::TDATA_W'({w_prod, w_row});
    assign m_axis_tuser  = w_sat;

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            $past(w_ctl[mx4_pkg::DIM].valid
                  && w_ctl[mx4_pkg::DIM].kind == mx4_pkg::KIND_MUL))
        else $error("result beat without a multiply row leaving the chain");

    a_sat_extreme : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (w_prod[0] == SAT_HI || w_prod[0] == SAT_LO
             || w_prod[1] == SAT_HI || w_prod[1] == SAT_LO
             || w_prod[2] == SAT_HI || w_prod[2] == SAT_LO
             || w_prod[3] == SAT_HI || w_prod[3] == SAT_LO))
        else $error("saturation flag without a clipped column");

endmodule

// File: design/mx4_cell.sv
// one cell of the multiplier chain: holds one row of b and adds its term
// of every dot product to the partial sums handed on to the next cell
// depends on mx4_pkg

module mx4_cell #(
    parameter int unsigned ELEM_WIDTH = mx4_pkg::DEF_ELEM_WIDTH,
    parameter int unsigned IDX        = 0
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_en,
    input  mx4_pkg::t_ctl                                      i_ctl,
    input  logic [mx4_pkg::DIM-1:0][ELEM_WIDTH-1:0]            i_elem,
    input  logic [mx4_pkg::DIM-1:0][2*ELEM_WIDTH+1:0]          i_acc,
    output mx4_pkg::t_ctl                                      o_ctl,
    output logic [mx4_pkg::DIM-1:0][ELEM_WIDTH-1:0]            o_elem,
    output logic [mx4_pkg::DIM-1:0][2*ELEM_WIDTH+1:0]          o_acc
);

    localparam int unsigned ACC_W  = 2 * ELEM_WIDTH + 2;
    localparam int unsigned PROD_W = 2 * ELEM_WIDTH;

    logic [mx4_pkg::DIM-1:0][ELEM_WIDTH-1:0] r_b;

    mx4_pkg::t_ctl                            r1_ctl;
    logic [mx4_pkg::DIM-1:0][ELEM_WIDTH-1:0]  r1_elem;
    logic [mx4_pkg::DIM-1:0][ACC_W-1:0]       r1_acc;
    logic signed [PROD_W-1:0]                 r1_prod [mx4_pkg::DIM];

    mx4_pkg::t_ctl                            r2_ctl;
    logic [mx4_pkg::DIM-1:0][ELEM_WIDTH-1:0]  r2_elem;
    logic [mx4_pkg::DIM-1:0][ACC_W-1:0]       r2_acc;

    logic w_load;

    assign w_load = i_en && i_ctl.valid && (i_ctl.kind == mx4_pkg::KIND_LOAD)
                    && (i_ctl.row == mx4_pkg::ROW_W'(IDX));

    // b row store
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_b <= i_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    // multiply stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_elem <= i_elem;
            r1_acc  <= i_acc;
            for (int j = 0; j < mx4_pkg::DIM; j++) begin
                r1_prod[j] <= $signed(i_elem[IDX]) * $signed(r_b[j]);
            end
            r2_elem <= r1_elem;
            for (int j = 0; j < mx4_pkg::DIM; j++) begin
                r2_acc[j] <= r1_acc[j]
                             + {{(ACC_W-PROD_W){r1_prod[j][PROD_W-1]}}, r1_prod[j]};
            end
        end
    end

    assign o_ctl  = r2_ctl;
    assign o_elem = r2_elem;
    assign o_acc  = r2_acc;

endmodule

// File: design/mx4_sat.sv
// end of the chain: shifts each full-width sum down by the fraction bits,
// clips it to the element range and holds the result beat
// depends on mx4_pkg

module mx4_sat #(
    parameter int unsigned FRAC_BITS  = mx4_pkg::DEF_FRAC_BITS,
    parameter int unsigned ELEM_WIDTH = mx4_pkg::DEF_ELEM_WIDTH
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  mx4_pkg::t_ctl                                 i_ctl,
    input  logic [mx4_pkg::DIM-1:0][2*ELEM_WIDTH+1:0]     i_acc,
    output logic                                          o_valid,
    output logic [mx4_pkg::ROW_W-1:0]                     o_row,
    output logic [mx4_pkg::DIM-1:0][mx4_pkg::OUT_W-1:0]   o_prod,
    output logic                                          o_sat
);

    localparam int unsigned ACC_W = 2 * ELEM_WIDTH + 2;

    localparam logic signed [ACC_W-1:0] MAXV =
        {{(ACC_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MINV = ~MAXV;
    localparam logic [ELEM_WIDTH-1:0] CLIP_HI = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] CLIP_LO = ~CLIP_HI;

    logic signed [ACC_W-1:0]                      w_shift [mx4_pkg::DIM];
    logic [ELEM_WIDTH-1:0]                        w_clip  [mx4_pkg::DIM];
    logic [mx4_pkg::DIM-1:0]                      w_over;
    logic [mx4_pkg::DIM-1:0][mx4_pkg::OUT_W-1:0]  n_prod;

    logic                                         r_valid;
    logic [mx4_pkg::ROW_W-1:0]                    r_row;
    logic [mx4_pkg::DIM-1:0][mx4_pkg::OUT_W-1:0]  r_prod;
    logic                                         r_sat;

    always_comb begin
        for (int j = 0; j < mx4_pkg::DIM; j++) begin
            w_shift[j] = $signed(i_acc[j]) >>> FRAC_BITS;
            if (w_shift[j] > MAXV) begin
                w_clip[j] = CLIP_HI;
                w_over[j] = 1'b1;
            end else if (w_shift[j] < MINV) begin
                w_clip[j] = CLIP_LO;
                w_over[j] = 1'b1;
            end else begin
                w_clip[j] = w_shift[j][ELEM_WIDTH-1:0];
                w_over[j] = 1'b0;
            end
            n_prod[j] = {{(mx4_pkg::OUT_W-ELEM_WIDTH){w_clip[j][ELEM_WIDTH-1]}}, w_clip[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid && (i_ctl.kind == mx4_pkg::KIND_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row  <= i_ctl.row;
            r_prod <= n_prod;
            r_sat  <= |w_over;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_prod  = r_prod;
    assign o_sat   = r_sat;

endmodule
